>>> hdl/irpw_pkg.sv
// ----------------------------------------------------------------------------
// irpw_pkg
// Shared types and constants for the IR pulse-width frame decoder.
// ----------------------------------------------------------------------------
package irpw_pkg;

	// Widths fixed by the field definitions
	localparam int CFG_W       = 16;
	localparam int NUM_CFG     = 8;
	localparam int CFG_IDX_W   = 3;
	localparam int WORD_W      = 32;
	localparam int CNT_W       = 5;
	localparam int MODE_W      = 2;
	localparam int CLS_W       = 3;

	// Bits per frame; the count runs 0 .. FRAME_BITS-1
	localparam int FRAME_BITS  = 32;

	// Default timestamp width
	localparam int TIME_WIDTH_DEF = 16;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_START_MIN = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START_MAX = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_MIN  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_MAX  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ONE_MIN   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ONE_MAX   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_PAUSE_MIN = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_PAUSE_MAX = 3'd7;

	// Register reset values
	localparam logic [CFG_W-1:0] RST_START_MIN = 16'd8200;
	localparam logic [CFG_W-1:0] RST_START_MAX = 16'd10000;
	localparam logic [CFG_W-1:0] RST_ZERO_MIN  = 16'd400;
	localparam logic [CFG_W-1:0] RST_ZERO_MAX  = 16'd700;
	localparam logic [CFG_W-1:0] RST_ONE_MIN   = 16'd1400;
	localparam logic [CFG_W-1:0] RST_ONE_MAX   = 16'd1900;
	localparam logic [CFG_W-1:0] RST_PAUSE_MIN = 16'd4200;
	localparam logic [CFG_W-1:0] RST_PAUSE_MAX = 16'd4800;

	// Event kinds
	localparam logic [MODE_W-1:0] MODE_EDGE    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_TIMEOUT = 2'd1;
	localparam logic [MODE_W-1:0] MODE_ACK     = 2'd2;

	// Pulse classes
	localparam logic [CLS_W-1:0] CLS_START = 3'd0;
	localparam logic [CLS_W-1:0] CLS_ZERO  = 3'd1;
	localparam logic [CLS_W-1:0] CLS_ONE   = 3'd2;
	localparam logic [CLS_W-1:0] CLS_PAUSE = 3'd3;
	localparam logic [CLS_W-1:0] CLS_ERROR = 3'd4;
	localparam logic [CLS_W-1:0] CLS_NONE  = 3'd5;

	// One result transaction
	typedef struct packed {
		logic              frame_ready;
		logic [WORD_W-1:0] code_word;
		logic [CNT_W-1:0]  bits_received;
		logic [CLS_W-1:0]  pulse_class;
	} result_t;

endpackage

>>> hdl/ir_pulse_width_frame_decoder_top.sv
// ----------------------------------------------------------------------------
// ir_pulse_width_frame_decoder_top
// Classifies IR edge intervals against configurable windows and assembles
// a 32-bit code word with a sticky frame-ready flag.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+----------------------------------
//  in      | input     | in_valid/in_stall  | mode, capture_time
//  out     | output    | out_valid/out_stall| frame_ready, code_word,
//          |           |                    | bits_received, pulse_class
//  cfg     | input     | cfg_wr_en          | cfg_index, cfg_data
//
//  One transaction per cycle while in_stall is low: the interval subtract, the
//  four window compares and the word shift settle combinationally and update
//  state at acceptance. Results leave from an output register backed by one
//  skid slot; in_stall rises only while the skid slot is occupied.
//  Each accepted result is registered in the output register or skid slot.
//  arst_n clears decoder state, the output queue and loads window defaults.
// ----------------------------------------------------------------------------
module ir_pulse_width_frame_decoder_top
	import irpw_pkg::*;
#(
	parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// Input channel
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [MODE_W-1:0]     mode,
	input  logic [TIME_WIDTH-1:0] capture_time,
	// Output channel
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  frame_ready,
	output logic [WORD_W-1:0]     code_word,
	output logic [CNT_W-1:0]      bits_received,
	output logic [CLS_W-1:0]      pulse_class,
	// Configuration write port
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]      cfg_data
);

	localparam int CMP_W = (TIME_WIDTH > CFG_W) ? TIME_WIDTH : CFG_W;

	// Configuration registers
	logic [CFG_W-1:0] cfg_q [NUM_CFG];

	// Decoder state
	logic [TIME_WIDTH-1:0] prev_time_q;
	logic [CNT_W-1:0]      bit_cnt_q;
	logic [WORD_W-1:0]     shift_word_q;
	logic                  ready_q;

	// Output queue
	logic    out_valid_q;
	logic    skid_valid_q;
	result_t out_q;
	result_t skid_q;

	// Next-state values
	logic [TIME_WIDTH-1:0] interval;
	logic [CMP_W-1:0]      ivl_x;
	logic                  hit_start, hit_zero, hit_one, hit_pause;
	logic [CNT_W:0]        cnt_inc;
	logic [CNT_W-1:0]      cnt_nxt;
	logic [WORD_W-1:0]     word_nxt;
	logic                  ready_nxt;
	logic [CLS_W-1:0]      cls_nxt;
	logic                  accept;
	logic                  take;
	result_t               res_nxt;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q[REG_START_MIN] <= RST_START_MIN;
			cfg_q[REG_START_MAX] <= RST_START_MAX;
			cfg_q[REG_ZERO_MIN]  <= RST_ZERO_MIN;
			cfg_q[REG_ZERO_MAX]  <= RST_ZERO_MAX;
			cfg_q[REG_ONE_MIN]   <= RST_ONE_MIN;
			cfg_q[REG_ONE_MAX]   <= RST_ONE_MAX;
			cfg_q[REG_PAUSE_MIN] <= RST_PAUSE_MIN;
			cfg_q[REG_PAUSE_MAX] <= RST_PAUSE_MAX;
		end else if (cfg_wr_en) begin
			cfg_q[cfg_index] <= cfg_data;
		end
	end

	// Interval and window compares (bounds inclusive)
	assign interval = capture_time - prev_time_q;
	assign ivl_x    = CMP_W'(interval);

	assign hit_start = (ivl_x >= CMP_W'(cfg_q[REG_START_MIN])) &&
	                   (ivl_x <= CMP_W'(cfg_q[REG_START_MAX]));
	assign hit_zero  = (ivl_x >= CMP_W'(cfg_q[REG_ZERO_MIN])) &&
	                   (ivl_x <= CMP_W'(cfg_q[REG_ZERO_MAX]));
	assign hit_one   = (ivl_x >= CMP_W'(cfg_q[REG_ONE_MIN])) &&
	                   (ivl_x <= CMP_W'(cfg_q[REG_ONE_MAX]));
	assign hit_pause = (ivl_x >= CMP_W'(cfg_q[REG_PAUSE_MIN])) &&
	                   (ivl_x <= CMP_W'(cfg_q[REG_PAUSE_MAX]));

	assign cnt_inc = {1'b0, bit_cnt_q} + 1'b1;

	// Classification and next state
	always_comb begin
		cnt_nxt   = bit_cnt_q;
		word_nxt  = shift_word_q;
		ready_nxt = ready_q;
		cls_nxt   = CLS_NONE;
		case (mode)
			MODE_EDGE: begin
				if (hit_start) begin
					cls_nxt  = CLS_START;
					cnt_nxt  = '0;
					word_nxt = '0;
				end else if (hit_zero || hit_one) begin
					cls_nxt  = hit_zero ? CLS_ZERO : CLS_ONE;
					word_nxt = {shift_word_q[WORD_W-2:0], ~hit_zero};
					// frame complete: flag it and restart the count
					if (cnt_inc == (CNT_W+1)'(FRAME_BITS)) begin
						ready_nxt = 1'b1;
						cnt_nxt   = '0;
					end else begin
						cnt_nxt = cnt_inc[CNT_W-1:0];
					end
				end else if (hit_pause) begin
					cls_nxt = CLS_PAUSE;
					cnt_nxt = '0;
				end else begin
					cls_nxt  = CLS_ERROR;
					cnt_nxt  = '0;
					word_nxt = '0;
				end
			end
			MODE_TIMEOUT: begin
				cnt_nxt   = '0;
				word_nxt  = '0;
				ready_nxt = 1'b0;
			end
			MODE_ACK: begin
				ready_nxt = 1'b0;
			end
			default: begin
				// unused code: state holds
			end
		endcase
	end

	assign res_nxt.frame_ready   = ready_nxt;
	assign res_nxt.code_word     = word_nxt;
	assign res_nxt.bits_received = cnt_nxt;
	assign res_nxt.pulse_class   = cls_nxt;

	// Handshake
	assign in_stall = skid_valid_q;
	assign accept   = in_valid && !skid_valid_q;
	assign take     = out_valid_q && !out_stall;

	// Decoder state update on each accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_time_q  <= '0;
			bit_cnt_q    <= '0;
			shift_word_q <= '0;
			ready_q      <= 1'b0;
		end else if (accept) begin
			if (mode == MODE_EDGE) begin
				prev_time_q <= capture_time;
			end
			bit_cnt_q    <= cnt_nxt;
			shift_word_q <= word_nxt;
			ready_q      <= ready_nxt;
		end
	end

	// Output register with one skid slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (accept) begin
			if (out_valid_q && !take) begin
				skid_valid_q <= 1'b1;
			end
			out_valid_q <= 1'b1;
		end else if (take) begin
			out_valid_q <= 1'b0;
		end
	end

	// Payload of the output queue
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take) begin
				out_q <= skid_q;
			end
		end else if (accept) begin
			if (out_valid_q && !take) begin
				skid_q <= res_nxt;
			end else begin
				out_q <= res_nxt;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign frame_ready   = out_q.frame_ready;
	assign code_word     = out_q.code_word;
	assign bits_received = out_q.bits_received;
	assign pulse_class   = out_q.pulse_class;

endmodule

>>> hdl/irpw_checker.sv
// ----------------------------------------------------------------------------
// irpw_checker
// Port-level checks for the IR pulse-width frame decoder.
// ----------------------------------------------------------------------------
module irpw_checker
	import irpw_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_stall,
	input logic              frame_ready,
	input logic [WORD_W-1:0] code_word,
	input logic [CNT_W-1:0]  bits_received,
	input logic [CLS_W-1:0]  pulse_class
);

	// A stalled result transaction stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("out_valid dropped while stalled");

	// Start and error both clear the count and the word
	a_start_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (pulse_class == CLS_START || pulse_class == CLS_ERROR)
		|-> bits_received == '0 && code_word == '0)
		else $error("start/error did not clear count and word");

	// Pause clears the count
	a_pause_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pulse_class == CLS_PAUSE |-> bits_received == '0)
		else $error("pause did not clear count");

	// A data bit lands in bit 0 of the word
	a_bit_lsb: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (pulse_class == CLS_ZERO || pulse_class == CLS_ONE)
		|-> code_word[0] == (pulse_class == CLS_ONE))
		else $error("newest bit not in bit 0");

	// Class codes stay within the defined set, ready flag is driven
	a_cls_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pulse_class <= CLS_NONE && !$isunknown(frame_ready))
		else $error("undefined pulse class or ready flag");

endmodule

bind ir_pulse_width_frame_decoder_top irpw_checker u_irpw_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.frame_ready   (frame_ready),
	.code_word     (code_word),
	.bits_received (bits_received),
	.pulse_class   (pulse_class)
);

>>> sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the IR pulse-width frame decoder. A directed table
// walks the window edges, interval wrap, timeout, acknowledge and the unused
// event kind. It is followed by random traffic, mostly well-formed frames with
// some noise, under several window settings. Every result transaction is
// checked against a pinned row or an in-bench decoder tracking the same state.
// ----------------------------------------------------------------------------
module testbench;
	import irpw_pkg::*;

	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned HOLD_CYCLES = 80;

	typedef struct packed {
		logic [MODE_W-1:0]         kind;
		logic [TIME_WIDTH_DEF-1:0] stamp;
		logic                      pinned;
		result_t                   want;
	} probe_row_t;

	localparam result_t NO_CHECK    = '0;
	localparam result_t CLEAR_NONE  = '{1'b0, 32'd0, 5'd0, CLS_NONE};
	localparam result_t CLEAR_ERROR = '{1'b0, 32'd0, 5'd0, CLS_ERROR};
	localparam result_t CLEAR_START = '{1'b0, 32'd0, 5'd0, CLS_START};

	// Directed rows, default windows; expected value typed in where pinned
	localparam probe_row_t DIRECTED [24] = '{
		'{MODE_ACK,     16'h0000,  1'b1, CLEAR_NONE},
		'{MODE_TIMEOUT, 16'hFFFF,  1'b1, CLEAR_NONE},
		'{MODE_UNUSED,  16'hA5A5,  1'b1, CLEAR_NONE},
		'{MODE_EDGE,    16'd0,     1'b1, CLEAR_ERROR},
		'{MODE_EDGE,    16'd8200,  1'b1, CLEAR_START},
		'{MODE_EDGE,    16'd8600,  1'b1, '{1'b0, 32'd0, 5'd1, CLS_ZERO}},
		'{MODE_EDGE,    16'd9300,  1'b1, '{1'b0, 32'd0, 5'd2, CLS_ZERO}},
		'{MODE_EDGE,    16'd10700, 1'b1, '{1'b0, 32'd1, 5'd3, CLS_ONE}},
		'{MODE_EDGE,    16'd12600, 1'b1, '{1'b0, 32'd3, 5'd4, CLS_ONE}},
		'{MODE_EDGE,    16'd16800, 1'b1, '{1'b0, 32'd3, 5'd0, CLS_PAUSE}},
		'{MODE_EDGE,    16'd21600, 1'b1, '{1'b0, 32'd3, 5'd0, CLS_PAUSE}},
		'{MODE_EDGE,    16'd22001, 1'b0, NO_CHECK},
		'{MODE_EDGE,    16'd22400, 1'b1, CLEAR_ERROR},
		'{MODE_EDGE,    16'd32400, 1'b1, CLEAR_START},
		'{MODE_EDGE,    16'd33101, 1'b1, CLEAR_ERROR},
		'{MODE_EDGE,    16'hFFFF,  1'b1, CLEAR_ERROR},
		'{MODE_EDGE,    16'd599,   1'b0, NO_CHECK},
		'{MODE_EDGE,    16'd2499,  1'b0, NO_CHECK},
		'{MODE_UNUSED,  16'h5A5A,  1'b0, NO_CHECK},
		'{MODE_TIMEOUT, 16'd0,     1'b1, CLEAR_NONE},
		'{MODE_EDGE,    16'd4199,  1'b0, NO_CHECK},
		'{MODE_ACK,     16'hFFFF,  1'b0, NO_CHECK},
		'{MODE_EDGE,    16'd14199, 1'b1, CLEAR_START},
		'{MODE_EDGE,    16'd24200, 1'b1, CLEAR_ERROR}
	};

	// DUT connections
	logic                      clk;
	logic                      arst_n        = 1'b0;
	logic                      in_valid      = 1'b0;
	logic                      in_stall;
	logic [MODE_W-1:0]         mode          = MODE_EDGE;
	logic [TIME_WIDTH_DEF-1:0] capture_time  = '0;
	logic                      out_valid;
	logic                      out_stall     = 1'b0;
	logic                      frame_ready;
	logic [WORD_W-1:0]         code_word;
	logic [CNT_W-1:0]          bits_received;
	logic [CLS_W-1:0]          pulse_class;
	logic                      cfg_wr_en     = 1'b0;
	logic [CFG_IDX_W-1:0]      cfg_index     = REG_START_MIN;
	logic [CFG_W-1:0]          cfg_data      = '0;

	// Typed-in expectation that travels with the offered transaction
	logic                      row_pinned    = 1'b0;
	result_t                   row_want      = '0;

	// Decoder shadow state and window copy
	logic [CFG_W-1:0] window_reg [NUM_CFG] = '{RST_START_MIN, RST_START_MAX,
		RST_ZERO_MIN, RST_ZERO_MAX, RST_ONE_MIN, RST_ONE_MAX,
		RST_PAUSE_MIN, RST_PAUSE_MAX};
	logic [TIME_WIDTH_DEF-1:0] prev_stamp   = '0;
	logic [5:0]                bits_seen    = '0;
	logic [WORD_W-1:0]         word_shift   = '0;
	logic                      ready_sticky = 1'b0;

	result_t decoded_events [$];
	int unsigned bad_decodes     = 0;
	int unsigned decodes_checked = 0;
	int unsigned frames_flagged  = 0;
	int unsigned items_offered   = 0;
	int unsigned settings_used   = 1;

	// Flow control knobs shared by the stimulus and the receiver
	bit                        tx_quiet = 1'b0;
	bit                        rx_quiet = 1'b0;
	int unsigned               hold_req = 0;
	logic [TIME_WIDTH_DEF-1:0] sent_edge = '0;

	ir_pulse_width_frame_decoder_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.mode          (mode),
		.capture_time  (capture_time),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.frame_ready   (frame_ready),
		.code_word     (code_word),
		.bits_received (bits_received),
		.pulse_class   (pulse_class),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Inclusive window test on the shadow registers
	function automatic bit fits(logic [TIME_WIDTH_DEF-1:0] width,
		logic [CFG_IDX_W-1:0] lo_reg, logic [CFG_IDX_W-1:0] hi_reg);
		return width >= window_reg[lo_reg] && width <= window_reg[hi_reg];
	endfunction

	// Shadow decoder: advance state by one event, return the visible result
	function automatic result_t decode_event(logic [MODE_W-1:0] kind,
		logic [TIME_WIDTH_DEF-1:0] stamp);
		result_t r;
		logic [TIME_WIDTH_DEF-1:0] width;
		logic [CLS_W-1:0] cls;
		cls = CLS_NONE;
		case (kind)
			MODE_EDGE: begin
				width = stamp - prev_stamp;
				prev_stamp = stamp;
				if (fits(width, REG_START_MIN, REG_START_MAX)) begin
					cls = CLS_START;
					bits_seen = '0;
					word_shift = '0;
				end else if (fits(width, REG_ZERO_MIN, REG_ZERO_MAX)) begin
					cls = CLS_ZERO;
					word_shift = {word_shift[WORD_W-2:0], 1'b0};
					bits_seen++;
				end else if (fits(width, REG_ONE_MIN, REG_ONE_MAX)) begin
					cls = CLS_ONE;
					word_shift = {word_shift[WORD_W-2:0], 1'b1};
					bits_seen++;
				end else if (fits(width, REG_PAUSE_MIN, REG_PAUSE_MAX)) begin
					cls = CLS_PAUSE;
					bits_seen = '0;
				end else begin
					cls = CLS_ERROR;
					bits_seen = '0;
					word_shift = '0;
				end
				// full word: latch ready and restart the count
				if (bits_seen >= FRAME_BITS) begin
					ready_sticky = 1'b1;
					bits_seen = '0;
					frames_flagged++;
				end
			end
			MODE_TIMEOUT: begin
				bits_seen = '0;
				word_shift = '0;
				ready_sticky = 1'b0;
			end
			MODE_ACK: begin
				ready_sticky = 1'b0;
			end
			default: ;
		endcase
		r.frame_ready   = ready_sticky;
		r.code_word     = word_shift;
		r.bits_received = bits_seen[CNT_W-1:0];
		r.pulse_class   = cls;
		return r;
	endfunction

	// Scoreboard: predict on input transactions, check output transactions
	always @(posedge clk) begin : scoreboard
		result_t got;
		result_t want;
		result_t model;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got = '{frame_ready, code_word, bits_received, pulse_class};
				if (decoded_events.size() == 0) begin
					bad_decodes++;
					if (bad_decodes <= 10)
						$display("unexpected result: ready %0b word %h bits %0d class %0d",
							got.frame_ready, got.code_word, got.bits_received,
							got.pulse_class);
				end else begin
					want = decoded_events.pop_front();
					decodes_checked++;
					if (got.frame_ready !== want.frame_ready ||
						got.code_word !== want.code_word ||
						got.bits_received !== want.bits_received ||
						got.pulse_class !== want.pulse_class) begin
						bad_decodes++;
						if (bad_decodes <= 10)
							$display("mismatch #%0d exp/act: ready %0b/%0b",
								decodes_checked, want.frame_ready, got.frame_ready,
								" word %h/%h bits %0d/%0d class %0d/%0d",
								want.code_word, got.code_word, want.bits_received,
								got.bits_received, want.pulse_class, got.pulse_class);
					end
				end
			end
			if (in_valid && !in_stall) begin
				model = decode_event(mode, capture_time);
				decoded_events.push_back(row_pinned ? row_want : model);
			end
		end
	end

	// Receiver: random stall after each transaction, plus long hold on request
	initial begin : receiver
		int unsigned stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (hold_req != 0) begin
				stall_left = hold_req;
				hold_req = 0;
			end else if (out_valid && !out_stall) begin
				stall_left = rx_quiet ? 0 : $urandom_range(12, 0);
			end
			if (stall_left != 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Watchdog
	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("TEST FAILED");
		$finish;
	end

	// Offer one transaction after a random gap and hold it until accepted
	task automatic offer(input logic [MODE_W-1:0] kind,
		input logic [TIME_WIDTH_DEF-1:0] stamp, input logic pinned,
		input result_t want);
		int unsigned gap;
		gap = tx_quiet ? 0 : $urandom_range(12, 0);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		mode         <= kind;
		capture_time <= stamp;
		row_pinned   <= pinned;
		row_want     <= want;
		items_offered++;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic send_edge(input logic [TIME_WIDTH_DEF-1:0] width);
		sent_edge = sent_edge + width;
		offer(MODE_EDGE, sent_edge, 1'b0, NO_CHECK);
	endtask

	// Interval inside the given class window; anything when the window is empty
	function automatic logic [TIME_WIDTH_DEF-1:0] pick_width(logic [CLS_W-1:0] cls);
		logic [CFG_W-1:0] lo;
		logic [CFG_W-1:0] hi;
		case (cls)
			CLS_START: begin
				lo = window_reg[REG_START_MIN];
				hi = window_reg[REG_START_MAX];
			end
			CLS_ZERO: begin
				lo = window_reg[REG_ZERO_MIN];
				hi = window_reg[REG_ZERO_MAX];
			end
			CLS_ONE: begin
				lo = window_reg[REG_ONE_MIN];
				hi = window_reg[REG_ONE_MAX];
			end
			CLS_PAUSE: begin
				lo = window_reg[REG_PAUSE_MIN];
				hi = window_reg[REG_PAUSE_MAX];
			end
			default: return TIME_WIDTH_DEF'($urandom);
		endcase
		if (lo <= hi)
			return TIME_WIDTH_DEF'($urandom_range(hi, lo));
		return TIME_WIDTH_DEF'($urandom);
	endfunction

	// One stray transaction: any event kind, any interval class
	task automatic send_noise();
		logic [MODE_W-1:0] kind;
		kind = MODE_W'($urandom_range(3, 0));
		if (kind == MODE_EDGE)
			send_edge(pick_width(CLS_W'($urandom_range(4, 0))));
		else
			offer(kind, TIME_WIDTH_DEF'($urandom), 1'b0, NO_CHECK);
	endtask

	// Start interval, a full word of bits with rare corruption, then an optional tail
	task automatic send_frame();
		send_edge(pick_width(CLS_START));
		for (int i = 0; i < FRAME_BITS; i++) begin
			if ($urandom_range(49, 0) == 0)
				send_noise();
			send_edge(pick_width($urandom_range(1, 0) ? CLS_ONE : CLS_ZERO));
		end
		case ($urandom_range(3, 0))
			0: offer(MODE_ACK, TIME_WIDTH_DEF'($urandom), 1'b0, NO_CHECK);
			1: offer(MODE_TIMEOUT, TIME_WIDTH_DEF'($urandom), 1'b0, NO_CHECK);
			2: send_edge(pick_width(CLS_PAUSE));
			default: ;
		endcase
	endtask

	task automatic run_random(input int unsigned budget);
		int unsigned stop_at;
		stop_at = items_offered + budget;
		while (items_offered < stop_at) begin
			tx_quiet = ($urandom_range(3, 0) == 0);
			rx_quiet = ($urandom_range(3, 0) == 0);
			if ($urandom_range(3, 0) != 0)
				send_frame();
			else
				repeat ($urandom_range(4, 1)) send_noise();
		end
	endtask

	// Stop offering and wait for every outstanding result
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (decoded_events.size() != 0) @(posedge clk);
	endtask

	task automatic set_window(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_W-1:0] value);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		window_reg[idx] = value;
	endtask

	// Rewrite all eight window bounds while the decoder is idle
	task automatic load_windows(input logic [CFG_W-1:0] s_lo, s_hi, z_lo, z_hi,
		o_lo, o_hi, p_lo, p_hi);
		drain();
		set_window(REG_START_MIN, s_lo);
		set_window(REG_START_MAX, s_hi);
		set_window(REG_ZERO_MIN, z_lo);
		set_window(REG_ZERO_MAX, z_hi);
		set_window(REG_ONE_MIN, o_lo);
		set_window(REG_ONE_MAX, o_hi);
		set_window(REG_PAUSE_MIN, p_lo);
		set_window(REG_PAUSE_MAX, p_hi);
		cfg_wr_en <= 1'b0;
		settings_used++;
	endtask

	// Back-to-back frame against a long receiver hold so the input backs up
	task automatic squeeze();
		tx_quiet = 1'b1;
		hold_req = HOLD_CYCLES;
		send_frame();
	endtask

	initial begin : stimulus
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part on reset windows
		foreach (DIRECTED[i]) begin
			offer(DIRECTED[i].kind, DIRECTED[i].stamp, DIRECTED[i].pinned,
				DIRECTED[i].want);
			if (DIRECTED[i].kind == MODE_EDGE)
				sent_edge = DIRECTED[i].stamp;
		end
		run_random(230);

		// scaled-down windows, with a backpressure burst
		load_windows(16'd2000, 16'd2500, 16'd100, 16'd150, 16'd300, 16'd380,
			16'd1000, 16'd1200);
		squeeze();
		run_random(230);

		// every window wide open: start wins everything
		load_windows(16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF,
			16'd0, 16'hFFFF);
		run_random(120);

		// inverted start window, single-point bit windows
		load_windows(16'hFFFF, 16'd0, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF,
			16'd1, 16'hFFFD);
		run_random(120);

		// overlapping windows, earlier class takes priority
		load_windows(16'd0, 16'd1000, 16'd500, 16'd2000, 16'd1500, 16'd3000,
			16'd2500, 16'd5000);
		run_random(230);

		// fully random bounds, twice
		repeat (2) begin
			load_windows(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom),
				CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom),
				CFG_W'($urandom), CFG_W'($urandom));
			run_random(190);
		end

		// back to the standard timing
		load_windows(RST_START_MIN, RST_START_MAX, RST_ZERO_MIN, RST_ZERO_MAX,
			RST_ONE_MIN, RST_ONE_MAX, RST_PAUSE_MIN, RST_PAUSE_MAX);
		run_random(230);

		drain();
		repeat (8) @(posedge clk);

		$display("Checked %0d decoder results from %0d events",
			decodes_checked, items_offered,
			" under %0d window settings.", settings_used);
		$display("Full frames flagged ready: %0d, mismatching results: %0d.",
			frames_flagged, bad_decodes);
		if (bad_decodes == 0 && decoded_events.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
